FILE: hw/rtl/i2ctpc_pkg.sv
// Package for the I2C timing parameter calculator.
// Holds the mode type, widths and the table of specification times in ns.
// Depends on nothing.
package i2ctpc_pkg;

   localparam int unsigned LANES    = 10;
   localparam int unsigned CNT_W    = 13;
   localparam int unsigned CLK_W    = 20;
   localparam int unsigned LANE_W   = 4;

   localparam logic [CLK_W-1:0] NS_PER_MS     = 20'd1000000;
   localparam logic [CLK_W-1:0] RESET_PERIOD  = 20'd20;
   localparam logic [15:0]      STD_LIMIT_KHZ = 16'd100;
   localparam logic [15:0]      FAST_LIMIT_KHZ = 16'd400;

   localparam logic [LANE_W-1:0] LANE_HIGH        = 4'd0;
   localparam logic [LANE_W-1:0] LANE_LOW         = 4'd1;
   localparam logic [LANE_W-1:0] LANE_FALL        = 4'd2;
   localparam logic [LANE_W-1:0] LANE_RISE        = 4'd3;
   localparam logic [LANE_W-1:0] LANE_START_HOLD  = 4'd4;
   localparam logic [LANE_W-1:0] LANE_START_SETUP = 4'd5;
   localparam logic [LANE_W-1:0] LANE_DATA_HOLD   = 4'd6;
   localparam logic [LANE_W-1:0] LANE_DATA_SETUP  = 4'd7;
   localparam logic [LANE_W-1:0] LANE_BUS_FREE    = 4'd8;
   localparam logic [LANE_W-1:0] LANE_STOP_SETUP  = 4'd9;

   typedef enum logic [1:0] {
      MODE_STD       = 2'd0,
      MODE_FAST      = 2'd1,
      MODE_FAST_PLUS = 2'd2
   } mode_type;

   function automatic logic [CNT_W-1:0] spec_ns(input logic [LANE_W-1:0] lane,
                                                input mode_type mode);
      logic [CNT_W-1:0] t;
      t = '0;
      unique case (lane)
         LANE_HIGH, LANE_START_HOLD, LANE_STOP_SETUP:
            t = (mode == MODE_STD) ? 13'd4000 : (mode == MODE_FAST) ? 13'd600 : 13'd260;
         LANE_LOW:
            t = (mode == MODE_STD) ? 13'd4700 : (mode == MODE_FAST) ? 13'd1300 : 13'd150;
         LANE_FALL:        t = 13'd12;
         LANE_RISE:        t = 13'd120;
         LANE_START_SETUP:
            t = (mode == MODE_STD) ? 13'd4700 : (mode == MODE_FAST) ? 13'd600 : 13'd260;
         LANE_DATA_HOLD:   t = (mode == MODE_STD) ? 13'd5000 : 13'd1;
         LANE_DATA_SETUP:
            t = (mode == MODE_STD) ? 13'd250 : (mode == MODE_FAST) ? 13'd100 : 13'd50;
         LANE_BUS_FREE:
            t = (mode == MODE_STD) ? 13'd4700 : (mode == MODE_FAST) ? 13'd1300 : 13'd500;
         default:          t = 13'd1;
      endcase
      return t;
   endfunction

endpackage

FILE: hw/rtl/i2c_timing_parameter_calculator.sv
// I2C timing parameter calculator: top level with the period divider and
// the pipelined array of ceiling dividers. Depends on i2ctpc_pkg.
//
// Usage: csr_we with csr_wdata writes the system clock in kHz. After a
// write, busy stays high while the clock period in ns is
// found by a restoring divider that yields one quotient bit per cycle.
// A transaction enters when start is high and busy is low; req_speed_khz
// picks standard, fast or fast-plus mode. Ten ceiling divisions by the
// period run side by side through a 13-stage pipeline, one quotient bit
// per stage, followed by one stage that adds one and applies the low-time
// and bus-free minimums. A new transaction may enter every cycle while
// busy is low, and its result leaves the output stage for one cycle with
// rsp_valid high; the receiver cannot stall, so the pipeline never holds.
// Reset clears all valid bits, loads the 20 ns period of a 50000 kHz
// clock at once, and leaves busy low.
module i2c_timing_parameter_calculator
   import i2ctpc_pkg::*;
(
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 start,
   output logic                 busy,
   input  logic [15:0]          req_speed_khz,
   input  logic                 csr_we,
   input  logic [CLK_W-1:0]     csr_wdata,
   output logic                 rsp_valid,
   output logic [CNT_W-1:0]     rsp_high_cycles,
   output logic [CNT_W-1:0]     rsp_low_cycles,
   output logic [CNT_W-1:0]     rsp_fall_cycles,
   output logic [CNT_W-1:0]     rsp_rise_cycles,
   output logic [CNT_W-1:0]     rsp_start_hold_cycles,
   output logic [CNT_W-1:0]     rsp_start_setup_cycles,
   output logic [CNT_W-1:0]     rsp_data_hold_cycles,
   output logic [CNT_W-1:0]     rsp_data_setup_cycles,
   output logic [CNT_W-1:0]     rsp_bus_free_cycles,
   output logic [CNT_W-1:0]     rsp_stop_setup_cycles
);

   localparam int unsigned STAGES = CNT_W;

   // Period divider.
   logic                div_busy_ff, div_busy_in;
   logic [4:0]          div_cnt_ff, div_cnt_in;
   logic [CLK_W:0]      div_rem_ff, div_rem_in;
   logic [CLK_W-1:0]    div_quo_ff, div_quo_in;
   logic [CLK_W-1:0]    div_den_ff, div_den_in;
   logic [CLK_W-1:0]    period_ff, period_in;
   logic [CLK_W:0]      div_shift;

   always_comb begin
      div_busy_in = div_busy_ff;
      div_cnt_in  = div_cnt_ff;
      div_rem_in  = div_rem_ff;
      div_quo_in  = div_quo_ff;
      div_den_in  = div_den_ff;
      period_in   = period_ff;
      div_shift   = {div_rem_ff[CLK_W-1:0], NS_PER_MS[5'(CLK_W-1) - div_cnt_ff]};
      if (csr_we) begin
         div_busy_in = 1'b1;
         div_cnt_in  = '0;
         div_rem_in  = '0;
         div_quo_in  = '0;
         div_den_in  = (csr_wdata == '0) ? CLK_W'(1) : csr_wdata;
      end else if (div_busy_ff) begin
         if (div_shift >= {1'b0, div_den_ff}) begin
            div_rem_in = div_shift - {1'b0, div_den_ff};
            div_quo_in = {div_quo_ff[CLK_W-2:0], 1'b1};
         end else begin
            div_rem_in = div_shift;
            div_quo_in = {div_quo_ff[CLK_W-2:0], 1'b0};
         end
         div_cnt_in = div_cnt_ff + 5'd1;
         if (div_cnt_ff == 5'(CLK_W-1)) begin
            div_busy_in = 1'b0;
            period_in   = (div_quo_in == '0) ? CLK_W'(1) : div_quo_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         div_busy_ff <= 1'b0;
         div_cnt_ff  <= '0;
         period_ff   <= RESET_PERIOD;
      end else begin
         div_busy_ff <= div_busy_in;
         div_cnt_ff  <= div_cnt_in;
         period_ff   <= period_in;
      end
      div_rem_ff <= div_rem_in;
      div_quo_ff <= div_quo_in;
      div_den_ff <= div_den_in;
   end

   assign busy = div_busy_ff;

   // Input stage: numerators t - 1 per lane.
   logic                 accept;
   mode_type             mode;
   logic                 vld_ff [0:STAGES];
   logic [CNT_W-1:0]     num_ff [0:STAGES][0:LANES-1];
   logic [CNT_W-1:0]     rem_ff [0:STAGES][0:LANES-1];
   logic [CNT_W-1:0]     quo_ff [0:STAGES][0:LANES-1];

   assign accept = start && !busy;

   always_comb begin
      if (req_speed_khz > FAST_LIMIT_KHZ)      mode = MODE_FAST_PLUS;
      else if (req_speed_khz > STD_LIMIT_KHZ)  mode = MODE_FAST;
      else                                     mode = MODE_STD;
   end

   always_ff @(posedge clock) begin
      if (reset) vld_ff[0] <= 1'b0;
      else       vld_ff[0] <= accept;
      for (int l = 0; l < LANES; l++) begin
         num_ff[0][l] <= spec_ns(LANE_W'(l), mode) - CNT_W'(1);
         rem_ff[0][l] <= '0;
         quo_ff[0][l] <= '0;
      end
   end

   // Division stages, one quotient bit per stage.
   for (genvar s = 0; s < STAGES; s++) begin : g_stage
      localparam int unsigned BIT = STAGES - 1 - s;
      logic [CNT_W:0]   shift [0:LANES-1];
      logic             fits  [0:LANES-1];

      always_comb begin
         for (int l = 0; l < LANES; l++) begin
            shift[l] = {rem_ff[s][l], num_ff[s][l][BIT]};
            fits[l]  = {{(CLK_W-CNT_W-1){1'b0}}, shift[l]} >= period_ff;
         end
      end

      always_ff @(posedge clock) begin
         if (reset) vld_ff[s+1] <= 1'b0;
         else       vld_ff[s+1] <= vld_ff[s];
         for (int l = 0; l < LANES; l++) begin
            num_ff[s+1][l] <= num_ff[s][l];
            rem_ff[s+1][l] <= fits[l] ? CNT_W'(shift[l] - period_ff[CNT_W:0])
                                      : shift[l][CNT_W-1:0];
            quo_ff[s+1][l] <= {quo_ff[s][l][CNT_W-2:0], fits[l]};
         end
      end
   end

   // Output stage.
   logic [CNT_W-1:0] cnt [0:LANES-1];
   logic [CNT_W-1:0] low_min, bus_min;

   always_comb begin
      for (int l = 0; l < LANES; l++) cnt[l] = quo_ff[STAGES][l] + CNT_W'(1);
      low_min = cnt[LANE_DATA_HOLD] + CNT_W'(1);
      bus_min = cnt[LANE_START_SETUP] + CNT_W'(1);
   end

   always_ff @(posedge clock) begin
      if (reset) rsp_valid <= 1'b0;
      else       rsp_valid <= vld_ff[STAGES];
      rsp_high_cycles        <= cnt[LANE_HIGH];
      rsp_low_cycles         <= (cnt[LANE_LOW] < low_min) ? low_min : cnt[LANE_LOW];
      rsp_fall_cycles        <= cnt[LANE_FALL];
      rsp_rise_cycles        <= cnt[LANE_RISE];
      rsp_start_hold_cycles  <= cnt[LANE_START_HOLD];
      rsp_start_setup_cycles <= cnt[LANE_START_SETUP];
      rsp_data_hold_cycles   <= cnt[LANE_DATA_HOLD];
      rsp_data_setup_cycles  <= cnt[LANE_DATA_SETUP];
      rsp_bus_free_cycles    <= (cnt[LANE_BUS_FREE] < bus_min) ? bus_min : cnt[LANE_BUS_FREE];
      rsp_stop_setup_cycles  <= cnt[LANE_STOP_SETUP];
   end

   a_period_nonzero: assert property (@(posedge clock) disable iff (reset)
      period_ff != '0) else $error("clock period is zero");
   a_busy_after_write: assert property (@(posedge clock) disable iff (reset)
      csr_we |=> busy) else $error("busy not raised after a clock write");
   a_low_min: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_low_cycles > rsp_data_hold_cycles)
      else $error("low time below data hold plus one");
   a_bus_free_min: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_bus_free_cycles > rsp_start_setup_cycles)
      else $error("bus free time below start setup plus one");

endmodule

FILE: dv/i2c_timing_parameter_calculator_tb.sv
// Testbench for the I2C timing parameter calculator: predicts the ten timing
// counts per requested bus speed and checks each response in order.
// Depends on i2ctpc_pkg and the i2c_timing_parameter_calculator RTL.
`timescale 1ns / 100ps

module i2c_timing_parameter_calculator_tb;
   import i2ctpc_pkg::*;

   typedef struct packed {
      logic [CNT_W-1:0] high, low, fall, rise, sta_hold, sta_setup;
      logic [CNT_W-1:0] dat_hold, dat_setup, bus_free, sto_setup;
   } timing_type;

   localparam int unsigned WATCHDOG_LIMIT = 20000;
   localparam int unsigned SETTLE_CYCLES  = 40;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic start = 1'b0;
   logic busy;
   logic [15:0] req_speed_khz = '0;
   logic csr_we = 1'b0;
   logic [CLK_W-1:0] csr_wdata = '0;
   logic rsp_valid;
   wire timing_type rsp;

   logic [15:0] speed_queue[$];
   timing_type timing_queue[$];
   logic [CLK_W-1:0] clk_khz_model = 20'd50000;
   logic idle_enable = 1'b1;
   int unsigned mismatches = 0;
   int unsigned idle_cycles = 0;
   bit timed_out = 1'b0;

   logic [CLK_W-1:0] clock_list [9] = '{20'd1, 20'd1000000, 20'd0, 20'hFFFFF, 20'd100000,
                                        20'd24000, 20'd333, 20'd1, 20'd50000};
   logic [15:0] corner_speeds [11] = '{16'd0, 16'd1, 16'd99, 16'd100, 16'd101, 16'd399,
                                       16'd400, 16'd401, 16'hFFFF, 16'h5555, 16'hAAAA};

   i2c_timing_parameter_calculator i_dut (
      .clock(clock), .reset(reset), .start(start), .busy(busy),
      .req_speed_khz(req_speed_khz), .csr_we(csr_we), .csr_wdata(csr_wdata),
      .rsp_valid(rsp_valid),
      .rsp_high_cycles(rsp.high), .rsp_low_cycles(rsp.low),
      .rsp_fall_cycles(rsp.fall), .rsp_rise_cycles(rsp.rise),
      .rsp_start_hold_cycles(rsp.sta_hold), .rsp_start_setup_cycles(rsp.sta_setup),
      .rsp_data_hold_cycles(rsp.dat_hold), .rsp_data_setup_cycles(rsp.dat_setup),
      .rsp_bus_free_cycles(rsp.bus_free), .rsp_stop_setup_cycles(rsp.sto_setup)
   );

   always #6 clock = ~clock;

   function automatic logic [CNT_W-1:0] cycles_for(int unsigned ns, int unsigned period);
      return CNT_W'((ns == 0) ? 0 : (ns - 1) / period + 1);
   endfunction

   function automatic timing_type bus_timing(logic [15:0] speed, logic [CLK_W-1:0] khz);
      int unsigned clk, period;
      logic [CNT_W-1:0] hd, su;
      mode_type mode;
      timing_type t;
      clk = (khz == '0) ? 1 : 32'(khz);
      period = 1000000 / clk;
      if (period == 0) period = 1;
      mode = (speed > 16'd400) ? MODE_FAST_PLUS : (speed > 16'd100) ? MODE_FAST : MODE_STD;
      case (mode)
         MODE_STD: begin
            t.high = cycles_for(4000, period); t.low = cycles_for(4700, period);
            t.sta_hold = cycles_for(4000, period); t.sta_setup = cycles_for(4700, period);
            t.dat_hold = cycles_for(5000, period); t.dat_setup = cycles_for(250, period);
            t.bus_free = cycles_for(4700, period); t.sto_setup = cycles_for(4000, period);
         end
         MODE_FAST: begin
            t.high = cycles_for(600, period); t.low = cycles_for(1300, period);
            t.sta_hold = cycles_for(600, period); t.sta_setup = cycles_for(600, period);
            t.dat_hold = cycles_for(1, period); t.dat_setup = cycles_for(100, period);
            t.bus_free = cycles_for(1300, period); t.sto_setup = cycles_for(600, period);
         end
         default: begin
            t.high = cycles_for(260, period); t.low = cycles_for(150, period);
            t.sta_hold = cycles_for(260, period); t.sta_setup = cycles_for(260, period);
            t.dat_hold = cycles_for(1, period); t.dat_setup = cycles_for(50, period);
            t.bus_free = cycles_for(500, period); t.sto_setup = cycles_for(260, period);
         end
      endcase
      t.fall = cycles_for(12, period);
      t.rise = cycles_for(120, period);
      hd = t.dat_hold;
      su = t.sta_setup;
      if (t.low < hd + CNT_W'(1)) t.low = hd + CNT_W'(1);
      if (t.bus_free < su + CNT_W'(1)) t.bus_free = su + CNT_W'(1);
      return t;
   endfunction

   // Driver: a transaction is accepted at an edge with start high and busy low.
   always @(posedge clock) begin
      if (reset) begin
         start <= 1'b0;
      end else begin
         if (start && !busy) begin
            timing_queue.push_back(bus_timing(req_speed_khz, clk_khz_model));
            void'(speed_queue.pop_front());
         end
         if ((!start || !busy) && speed_queue.size() > 0
             && (!idle_enable || $urandom_range(99) >= 28)) begin
            start <= 1'b1;
            req_speed_khz <= speed_queue[0];
         end else if (!start || !busy) begin
            start <= 1'b0;
         end
      end
   end

   // Monitor and watchdog.
   always @(posedge clock) begin
      timing_type exp_t;
      if (!reset) begin
         if (rsp_valid) begin
            if (timing_queue.size() == 0) begin
               mismatches++;
               if (mismatches <= 10) $display("Unexpected transaction: %p", rsp);
            end else begin
               exp_t = timing_queue.pop_front();
               if (rsp !== exp_t) begin
                  mismatches++;
                  if (mismatches <= 10)
                     $display("Mismatch: expected %p, actual %p", exp_t, rsp);
               end
            end
         end
         if (rsp_valid || (start && !busy) || csr_we) idle_cycles = 0;
         else idle_cycles++;
         if (idle_cycles >= WATCHDOG_LIMIT && !timed_out) begin
            timed_out = 1'b1;
            $display("i2c_timing_parameter_calculator verification failed");
            $finish;
         end
      end
   end

   task automatic drain();
      while (speed_queue.size() > 0 || start || timing_queue.size() > 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic write_clock(logic [CLK_W-1:0] khz);
      csr_we <= 1'b1;
      csr_wdata <= khz;
      clk_khz_model = khz;
      @(posedge clock);
      csr_we <= 1'b0;
      @(posedge clock);
      while (busy) @(posedge clock);
   endtask

   function automatic logic [15:0] random_speed();
      case ($urandom_range(5))
         0: return 16'($urandom_range(100));
         1: return 16'($urandom_range(400, 101));
         2: return 16'($urandom_range(1000, 401));
         3: return 16'($urandom_range(101, 99) + 300 * $urandom_range(1));
         default: return 16'($urandom);
      endcase
   endfunction

   initial begin
      repeat (7) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      foreach (clock_list[c]) begin
         if (c > 0) write_clock(clock_list[c - 1]);
         if (c == 0 || c == 4) begin
            foreach (corner_speeds[i])
               speed_queue.push_back(corner_speeds[i]);
         end
         idle_enable = (c != 3);
         repeat (100) speed_queue.push_back(random_speed());
         drain();
      end
      if (mismatches == 0)
         $display("i2c_timing_parameter_calculator verification clean");
      else
         $display("i2c_timing_parameter_calculator verification failed");
      $finish;
   end

endmodule

FILE: sim.f
hw/rtl/i2ctpc_pkg.sv
hw/rtl/i2c_timing_parameter_calculator.sv
dv/i2c_timing_parameter_calculator_tb.sv
